// File: rtl/core/rag_pkg.sv
// Package for the region adjacency block: shared types and constants.
// Depends on nothing.
package rag_pkg;
    localparam int CfgAddrW = 3;
    localparam logic [CfgAddrW-1:0] AddrRows = 3'd0;
    localparam logic [CfgAddrW-1:0] AddrCols = 3'd4;
    localparam logic signed [8:0] BoundaryLabel = -9'sd1;
    typedef struct packed {
        logic       done;
        logic       err;
    } t_flags;
endpackage

// File: rtl/core/region_adjacency_from_watershed.sv
// Top level of the region adjacency block: column store, adjacency matrix, sequencer.
// Depends on rag_pkg.
//
// A word is accepted when start is high and busy is low; each result word sits on the
// outputs for one cycle under o_valid and the receiver cannot stall it. After reset, and
// at the first pixel of each frame, the block clears the matrix one entry a cycle
// while busy is high. A read goes through S_RD and S_OUT; a pixel that does not end a
// column goes through S_WR and S_OUT, and a pixel that ends the first column of a
// multi-column frame through S_WR, S_DONE and S_OUT. Any other pixel that ends a column
// scans the previous column, if there is one, and at the end of a frame the last column
// too, row by row; each boundary pixel adds neighbour reads, then up to 56 matrix writes,
// each a read-modify-write through the single write port of the matrix memory.
module region_adjacency_from_watershed #(
    parameter int MAX_ROWS   = 1024,
    parameter int MAX_COLS   = 4096,
    parameter int NUM_LABELS = 256
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [rag_pkg::CfgAddrW-1:0] paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready,
    input  logic                 start,
    output logic                 busy,
    input  logic                 i_opcode,
    input  logic signed [8:0]    i_pixel_label,
    input  logic [7:0]           i_row_region,
    input  logic [1:0]           i_word_index,
    output logic                 o_valid,
    output logic [63:0]          o_adjacency_word,
    output logic                 o_frame_done,
    output logic                 o_label_error
);
    localparam int RW = $clog2(MAX_ROWS);
    localparam int CW = $clog2(MAX_COLS) + 1;
    localparam int LW = $clog2(NUM_LABELS);
    localparam int NW = (NUM_LABELS + 63) / 64;
    localparam int MD = NUM_LABELS * NW;
    localparam int MA = $clog2(MD);
    localparam int SA = $clog2(3 * MAX_ROWS);

    localparam logic [3:0] S_IDLE = 4'd0, S_RD = 4'd1, S_OUT = 4'd2, S_CLR = 4'd3,
        S_WR = 4'd4, S_SCAN = 4'd5, S_NB = 4'd6, S_NBW = 4'd7, S_PAIR = 4'd8,
        S_PRMW = 4'd9, S_PWR = 4'd10, S_NEXT = 4'd11, S_DONE = 4'd12;

    logic [10:0] r_rows;
    logic [12:0] r_cols;
    logic [3:0]  r_st;
    logic [RW:0] r_row;
    logic [CW-1:0] r_col;
    logic [1:0]  r_slot;
    logic signed [8:0] r_lab;
    logic        r_op;
    logic [7:0]  r_rreg;
    logic [1:0]  r_widx;
    rag_pkg::t_flags r_flags;
    logic [MA-1:0] r_clr;
    logic        r_boot;
    // scan state
    logic [CW-1:0] r_sc;
    logic        r_second;
    logic [RW:0] r_si;
    logic [3:0]  r_nb;
    logic [7:0][LW-1:0] r_seen;
    logic [3:0]  r_n;
    logic [2:0]  r_p, r_q;
    logic [1:0]  r_slot_c;
    logic [1:0]  r_slot_m, r_slot_p;
    logic        r_center;

    logic signed [8:0] r_store [3*MAX_ROWS];
    logic signed [8:0] r_sq;
    logic [63:0] r_mat [MD];
    logic [63:0] r_mq;

    logic [RW:0] eff_rows;
    logic [CW-1:0] eff_cols;
    always_comb begin
        if (r_rows == 11'd0) eff_rows = (RW+1)'(1);
        else if (32'(r_rows) > MAX_ROWS) eff_rows = (RW+1)'(MAX_ROWS);
        else eff_rows = (RW+1)'(r_rows);
        if (r_cols == 13'd0) eff_cols = CW'(1);
        else if (32'(r_cols) > MAX_COLS) eff_cols = CW'(MAX_COLS);
        else eff_cols = CW'(r_cols);
    end

    logic cfg_wr;
    assign cfg_wr = psel && penable && pwrite;
    assign pready = 1'b1;
    always_comb begin
        unique case (paddr)
            rag_pkg::AddrRows: prdata = {21'd0, r_rows};
            rag_pkg::AddrCols: prdata = {19'd0, r_cols};
            default: prdata = 32'd0;
        endcase
    end

    logic accept;
    assign accept = start && !busy;
    assign busy = (r_st != S_IDLE);

    // neighbour offsets: nb 0..8 over dj,di, skip centre (4)
    logic signed [2:0] nb_di, nb_dj;
    always_comb begin
        case (r_nb) inside
            [4'd0:4'd2]: nb_dj = -3'sd1;
            [4'd3:4'd5]: nb_dj = 3'sd0;
            default: nb_dj = 3'sd1;
        endcase
        case (r_nb) inside
            4'd0, 4'd3, 4'd6: nb_di = -3'sd1;
            4'd1, 4'd4, 4'd7: nb_di = 3'sd0;
            default: nb_di = 3'sd1;
        endcase
    end
    logic signed [RW+2:0] nb_ii;
    logic signed [CW+1:0] nb_jj;
    assign nb_ii = signed'((RW+3)'(r_si)) + (RW+3)'(nb_di);
    assign nb_jj = signed'((CW+2)'(r_sc)) + (CW+2)'(nb_dj);
    logic nb_ok;
    assign nb_ok = (r_nb != 4'd4) && nb_ii >= 0 && nb_ii < signed'((RW+3)'(eff_rows))
        && nb_jj >= 0 && nb_jj < signed'((CW+2)'(eff_cols));
    logic [1:0] nb_slot;
    always_comb begin
        if (nb_dj < 0) nb_slot = r_slot_m;
        else if (nb_dj > 0) nb_slot = r_slot_p;
        else nb_slot = r_slot_c;
    end

    // store port
    logic st_we;
    logic [SA-1:0] st_wa, st_ra;
    always_comb begin
        st_we = (r_st == S_WR);
        st_wa = SA'(32'(r_slot) * MAX_ROWS + 32'(r_row));
        if (r_st == S_NB) st_ra = SA'(32'(nb_slot) * MAX_ROWS + 32'(nb_ii[RW:0]));
        else st_ra = SA'(32'(r_slot_c) * MAX_ROWS + 32'(r_si));
    end
    always_ff @(posedge i_clk) begin
        if (st_we) r_store[st_wa] <= r_lab;
        r_sq <= r_store[st_ra];
    end

    // matrix port
    logic [LW-1:0] pa, pb;
    assign pa = r_seen[r_p];
    assign pb = r_seen[r_q];
    logic mat_we;
    logic [MA-1:0] mat_wa, mat_ra;
    logic [63:0] mat_wd;
    always_comb begin
        mat_we = 1'b0;
        mat_wa = r_clr;
        mat_wd = 64'd0;
        mat_ra = MA'(32'(r_rreg) * NW + 32'(r_widx));
        if (r_st == S_CLR) mat_we = 1'b1;
        if (r_st == S_PAIR || r_st == S_PRMW || r_st == S_PWR)
            mat_ra = MA'(32'(pa) * NW + 32'(pb) / 64);
        if (r_st == S_PWR) begin
            mat_we = 1'b1;
            mat_wa = mat_ra;
            mat_wd = r_mq | (64'd1 << pb[5:0]);
        end
    end
    always_ff @(posedge i_clk) begin
        if (mat_we) r_mat[mat_wa] <= mat_wd;
        r_mq <= r_mat[mat_ra];
    end

    logic sv_dup;
    always_comb begin
        sv_dup = 1'b0;
        for (int k = 0; k < 8; k++)
            if (4'(k) < r_n && r_seen[k] == LW'(r_sq[LW-1:0])) sv_dup = 1'b1;
    end
    logic sq_valid;
    assign sq_valid = r_sq >= 0 && 32'(r_sq) < NUM_LABELS;

    logic [1:0] sl_m;
    always_comb sl_m = (r_slot == 2'd0) ? 2'd2 : r_slot - 2'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
            r_rows <= 11'd1024;
            r_cols <= 13'd1024;
            r_st <= S_CLR;
            r_clr <= '0;
            r_boot <= 1'b1;
            r_row <= '0;
            r_col <= '0;
            r_slot <= 2'd0;
        end else begin
            o_valid <= (r_st == S_OUT);
            if (cfg_wr) begin
                if (paddr == rag_pkg::AddrRows) r_rows <= pwdata[10:0];
                if (paddr == rag_pkg::AddrCols) r_cols <= pwdata[12:0];
                if (paddr == rag_pkg::AddrRows || paddr == rag_pkg::AddrCols) begin
                    r_row <= '0; r_col <= '0; r_slot <= 2'd0;
                end
            end
            unique case (r_st)
                S_IDLE: if (accept) begin
                    r_op <= i_opcode;
                    r_rreg <= i_row_region;
                    r_widx <= i_word_index;
                    r_lab <= i_pixel_label;
                    r_flags.done <= 1'b0;
                    r_flags.err <= (i_pixel_label < rag_pkg::BoundaryLabel) ||
                        (32'(i_pixel_label) >= NUM_LABELS && i_pixel_label >= 0);
                    if (i_opcode) r_st <= S_RD;
                    else begin
                        if (r_row >= eff_rows || r_col >= eff_cols) begin
                            r_row <= '0; r_col <= '0; r_slot <= 2'd0;
                            r_clr <= '0; r_st <= S_CLR;
                        end else if (r_row == '0 && r_col == '0) begin
                            r_clr <= '0; r_st <= S_CLR;
                        end else r_st <= S_WR;
                    end
                end
                S_RD: r_st <= S_OUT;
                S_CLR: begin
                    r_clr <= r_clr + MA'(1);
                    if (32'(r_clr) == MD - 1) begin
                        r_boot <= 1'b0;
                        r_st <= r_boot ? S_IDLE : S_WR;
                    end
                end
                S_WR: begin
                    if (r_flags.err) r_lab <= 9'sd0;
                    if (r_row + (RW+1)'(1) >= eff_rows) begin
                        r_row <= '0;
                        r_si <= '0;
                        r_second <= 1'b0;
                        if (r_col >= CW'(1)) begin
                            r_sc <= r_col - CW'(1);
                            r_slot_c <= sl_m; r_slot_m <= (sl_m == 2'd0) ? 2'd2 : sl_m - 2'd1;
                            r_slot_p <= r_slot;
                            r_st <= S_SCAN;
                        end else if (r_col + CW'(1) >= eff_cols) begin
                            r_sc <= r_col; r_second <= 1'b1;
                            r_slot_c <= r_slot; r_slot_m <= sl_m;
                            r_slot_p <= (r_slot == 2'd2) ? 2'd0 : r_slot + 2'd1;
                            r_st <= S_SCAN;
                        end else r_st <= S_DONE;
                    end else begin
                        r_row <= r_row + (RW+1)'(1);
                        r_st <= S_OUT;
                    end
                end
                S_SCAN: begin
                    r_nb <= 4'd0; r_n <= 4'd0; r_center <= 1'b1;
                    r_st <= S_NBW;
                end
                S_NB: begin
                    r_center <= 1'b0;
                    if (nb_ok) r_st <= S_NBW;
                    else if (r_nb == 4'd8) r_st <= S_PAIR;
                    else r_nb <= r_nb + 4'd1;
                    r_p <= 3'd0; r_q <= 3'd0;
                end
                S_NBW: begin
                    // r_sq holds the label read last cycle
                    if (r_center) begin
                        if (r_sq == rag_pkg::BoundaryLabel) r_st <= S_NB;
                        else r_st <= S_NEXT;
                    end else begin
                        if (sq_valid && !sv_dup && r_n < 4'd8) begin
                            r_seen[r_n[2:0]] <= LW'(r_sq[LW-1:0]);
                            r_n <= r_n + 4'd1;
                        end
                        if (r_nb == 4'd8) r_st <= S_PAIR;
                        else begin
                            r_nb <= r_nb + 4'd1;
                            r_st <= S_NB;
                        end
                    end
                end
                S_PAIR: begin
                    if (r_n < 4'd2 || 4'(r_p) >= r_n) r_st <= S_NEXT;
                    else if (4'(r_q) >= r_n) begin
                        r_q <= 3'd0;
                        if (4'(r_p) + 4'd1 >= r_n) r_st <= S_NEXT;
                        else r_p <= r_p + 3'd1;
                    end else if (r_p == r_q) begin
                        if (4'(r_q) + 4'd1 >= r_n) begin
                            r_q <= 3'd0;
                            if (4'(r_p) + 4'd1 >= r_n) r_st <= S_NEXT;
                            else r_p <= r_p + 3'd1;
                        end else r_q <= r_q + 3'd1;
                    end else r_st <= S_PRMW;
                end
                S_PRMW: r_st <= S_PWR;
                S_PWR: begin
                    if (4'(r_q) + 4'd1 >= r_n) begin
                        r_q <= 3'd0;
                        if (4'(r_p) + 4'd1 >= r_n) r_st <= S_NEXT;
                        else begin
                            r_p <= r_p + 3'd1;
                            r_st <= S_PAIR;
                        end
                    end else begin
                        r_q <= r_q + 3'd1;
                        r_st <= S_PAIR;
                    end
                end
                S_NEXT: begin
                    if (r_si + (RW+1)'(1) >= eff_rows) begin
                        if (!r_second && r_col + CW'(1) >= eff_cols) begin
                            r_second <= 1'b1;
                            r_sc <= r_col; r_si <= '0;
                            r_slot_m <= r_slot_c; r_slot_c <= r_slot_p;
                            r_slot_p <= r_slot_m;
                            r_st <= S_SCAN;
                        end else r_st <= S_DONE;
                    end else begin
                        r_si <= r_si + (RW+1)'(1);
                        r_st <= S_SCAN;
                    end
                end
                S_DONE: begin
                    if (r_col + CW'(1) >= eff_cols) begin
                        r_col <= '0; r_slot <= 2'd0;
                        r_flags.done <= 1'b1;
                    end else begin
                        r_col <= r_col + CW'(1);
                        r_slot <= (r_slot == 2'd2) ? 2'd0 : r_slot + 2'd1;
                    end
                    r_st <= S_OUT;
                end
                S_OUT: begin
                    o_adjacency_word <= (r_op && 32'(r_widx) < NW
                        && 32'(r_rreg) < NUM_LABELS) ? r_mq : 64'd0;
                    o_frame_done <= r_op ? 1'b0 : r_flags.done;
                    o_label_error <= r_op ? 1'b0 : r_flags.err;
                    r_st <= S_IDLE;
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

    a_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid) else $error("strobe held");
    a_busy_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> busy) else $error("busy not raised");
    a_read_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_adjacency_word != 64'd0 |-> !o_frame_done && !o_label_error)
        else $error("flags on read");
endmodule

// File: tb/sv/rag_checker.sv
`timescale 1ns / 100ps
// Checker for the region adjacency block: predicts every result word from the
// accepted items and register writes, and compares it. Depends on rag_pkg.
module rag_checker (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic              pready,
    input  logic [rag_pkg::CfgAddrW-1:0] paddr,
    input  logic [31:0]       pwdata,
    input  logic              start,
    input  logic              busy,
    input  logic              i_opcode,
    input  logic signed [8:0] i_pixel_label,
    input  logic [7:0]        i_row_region,
    input  logic [1:0]        i_word_index,
    input  logic              o_valid,
    input  logic [63:0]       o_adjacency_word,
    input  logic              o_frame_done,
    input  logic              o_label_error,
    output int                o_fail_count,
    output int                o_pending
);
    localparam int MaxRows = 1024;
    localparam int MaxCols = 4096;
    localparam int NumLabels = 256;

    typedef struct packed {
        logic [63:0]     word;
        rag_pkg::t_flags flags;
    } t_word;

    t_word                 expected_words[$];
    logic signed [8:0]     label_cols[3*MaxRows];
    logic [NumLabels-1:0]  adj_rows[NumLabels];
    int unsigned           rows_reg, cols_reg, cur_row, cur_col;

    assign o_pending = expected_words.size();

    function automatic int unsigned eff_rows();
        return (rows_reg < 1) ? 1 : (rows_reg > MaxRows) ? MaxRows : rows_reg;
    endfunction

    function automatic int unsigned eff_cols();
        return (cols_reg < 1) ? 1 : (cols_reg > MaxCols) ? MaxCols : cols_reg;
    endfunction

    function automatic int label_at(int c, int r);
        return int'(label_cols[(c % 3) * MaxRows + r]);
    endfunction

    function automatic void close_column(int c, int rows, int cols);
        int seen[8];
        int n, v;
        bit dup;
        for (int i = 0; i < rows; i++) begin
            if (label_at(c, i) != int'(rag_pkg::BoundaryLabel)) continue;
            n = 0;
            for (int dj = -1; dj <= 1; dj++) begin
                for (int di = -1; di <= 1; di++) begin
                    if (di == 0 && dj == 0) continue;
                    if (i + di < 0 || i + di >= rows) continue;
                    if (c + dj < 0 || c + dj >= cols) continue;
                    v = label_at(c + dj, i + di);
                    if (v < 0 || v >= NumLabels) continue;
                    dup = 0;
                    for (int p = 0; p < n; p++) if (seen[p] == v) dup = 1;
                    if (!dup && n < 8) begin
                        seen[n] = v;
                        n++;
                    end
                end
            end
            for (int p = 0; p < n; p++)
                for (int q = 0; q < n; q++)
                    if (p != q) adj_rows[seen[p]][seen[q]] = 1'b1;
        end
    endfunction

    function automatic t_word predict_word(logic op, logic signed [8:0] label,
                                           logic [7:0] region, logic [1:0] widx);
        t_word res;
        int rows, cols;
        res = '0;
        if (op) begin
            res.word = adj_rows[region][64*widx +: 64];
            return res;
        end
        rows = eff_rows();
        cols = eff_cols();
        res.flags.err = (label < rag_pkg::BoundaryLabel);
        if (cur_row >= rows || cur_col >= cols) begin
            cur_row = 0;
            cur_col = 0;
        end
        if (cur_row == 0 && cur_col == 0)
            for (int k = 0; k < NumLabels; k++) adj_rows[k] = '0;
        label_cols[(cur_col % 3) * MaxRows + cur_row] = label;
        if (cur_row + 1 >= rows) begin
            if (cur_col >= 1) close_column(cur_col - 1, rows, cols);
            if (cur_col + 1 >= cols) begin
                close_column(cur_col, rows, cols);
                res.flags.done = 1'b1;
                cur_col = 0;
            end else begin
                cur_col++;
            end
            cur_row = 0;
        end else begin
            cur_row++;
        end
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_word want;
        t_word got;
        t_word pred;
        if (!i_rst_n) begin
            expected_words.delete();
            for (int k = 0; k < NumLabels; k++) adj_rows[k] = '0;
            rows_reg = 1024;
            cols_reg = 1024;
            cur_row = 0;
            cur_col = 0;
            o_fail_count <= 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                if (paddr == rag_pkg::AddrRows) begin
                    rows_reg = pwdata & 32'h7FF;
                    cur_row = 0;
                    cur_col = 0;
                end else if (paddr == rag_pkg::AddrCols) begin
                    cols_reg = pwdata & 32'h1FFF;
                    cur_row = 0;
                    cur_col = 0;
                end
            end
            if (o_valid) begin
                got.word = o_adjacency_word;
                got.flags.done = o_frame_done;
                got.flags.err = o_label_error;
                if (expected_words.size() == 0) begin
                    if (o_fail_count < 10) $display("unexpected word %p", got);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = expected_words.pop_front();
                    if (got !== want) begin
                        if (o_fail_count < 10)
                            $display({"mismatch: expected word=%h done=%b err=%b, ",
                                      "got word=%h done=%b err=%b"},
                                     want.word, want.flags.done, want.flags.err,
                                     got.word, got.flags.done, got.flags.err);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            if (start && !busy) begin
                pred = predict_word(i_opcode, i_pixel_label, i_row_region, i_word_index);
                expected_words = {expected_words, pred};
            end
        end
    end
endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 100ps
// Testbench top for region_adjacency_from_watershed: drives frames, reads and
// register writes, and gives the verdict. Depends on rag_pkg and rag_checker.
module tb;
    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [rag_pkg::CfgAddrW-1:0] paddr = '0;
    logic [31:0]       pwdata = '0;
    logic [31:0]       prdata;
    logic              pready;
    logic              start = 1'b0;
    logic              busy;
    logic              i_opcode = 1'b0;
    logic signed [8:0] i_pixel_label = '0;
    logic [7:0]        i_row_region = '0;
    logic [1:0]        i_word_index = '0;
    logic              o_valid;
    logic [63:0]       o_adjacency_word;
    logic              o_frame_done;
    logic              o_label_error;
    int                fail_count, pending, quiet_cycles;
    int                burst_left = 0;

    localparam logic OpPixel = 1'b0;
    localparam logic OpRead = 1'b1;
    localparam int QuietLimit = 200000;

    always #10 i_clk = ~i_clk;

    region_adjacency_from_watershed dut (.*);

    rag_checker u_checker (
        .*, .o_fail_count(fail_count), .o_pending(pending)
    );

    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid || !i_rst_n) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QuietLimit) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic send_word(logic op, logic signed [8:0] label, logic [7:0] region,
                             logic [1:0] widx);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                start <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 20);
        end
        burst_left--;
        start <= 1'b1;
        i_opcode <= op;
        i_pixel_label <= label;
        i_row_region <= region;
        i_word_index <= widx;
        do @(posedge i_clk); while (busy);
    endtask

    task automatic drain();
        start <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [rag_pkg::CfgAddrW-1:0] addr, logic [31:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic random_word(int nlabels);
        int r;
        logic signed [8:0] label;
        r = $urandom_range(0, 99);
        if (r < 18) begin
            if ($urandom_range(0, 3) == 0)
                send_word(OpRead, 9'($urandom), 8'($urandom), 2'($urandom));
            else
                send_word(OpRead, 9'($urandom), 8'($urandom_range(0, nlabels - 1)),
                          2'($urandom_range(0, 1) ? 0 : $urandom_range(0, 3)));
        end else begin
            r = $urandom_range(0, 99);
            if (r < 35) label = rag_pkg::BoundaryLabel;
            else if (r < 40) label = -9'sd256 + 9'($urandom_range(0, 254));
            else if (r < 45) label = 9'($urandom_range(0, 255));
            else label = 9'($urandom_range(0, nlabels - 1));
            send_word(OpPixel, label, 8'($urandom), 2'($urandom));
        end
    endtask

    task automatic run_phase(int rows, int cols, int count, int nlabels);
        write_reg(rag_pkg::AddrRows, rows);
        write_reg(rag_pkg::AddrCols, cols);
        for (int k = 0; k < count; k++) begin
            random_word(nlabels);
            if (k == count / 2) drain();
        end
        drain();
    endtask

    initial begin
        logic signed [8:0] grid[9];
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        write_reg(rag_pkg::AddrRows, 3);
        write_reg(rag_pkg::AddrCols, 3);
        grid = '{9'sd5, -9'sd1, 9'sd255, 9'sd0, -9'sd1, 9'sd7, 9'sd9, -9'sd256, -9'sd1};
        for (int k = 0; k < 9; k++) send_word(OpPixel, grid[k], 8'd0, 2'd0);
        send_word(OpRead, 9'sd0, 8'd0, 2'd0);
        send_word(OpRead, 9'sd0, 8'd5, 2'd0);
        send_word(OpRead, 9'sd0, 8'd255, 2'd3);
        send_word(OpRead, 9'sd0, 8'd0, 2'd3);
        send_word(OpRead, 9'sd0, 8'd9, 2'd0);
        for (int k = 0; k < 4; k++) send_word(OpPixel, k[0] ? -9'sd1 : 9'sd3, 8'd0, 2'd0);
        send_word(OpRead, 9'sd0, 8'd3, 2'd0);
        send_word(OpPixel, -9'sd2, 8'hFF, 2'd3);
        drain();

        run_phase(4, 5, 300, 8);
        run_phase(3, 1, 120, 6);
        run_phase(7, 4, 300, 12);
        run_phase(5, 8191, 200, 10);
        run_phase(2047, 1, 60, 8);
        run_phase(1024, 4096, 60, 8);
        run_phase(6, 6, 300, 256);

        drain();
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule

// File: files.f
rtl/core/rag_pkg.sv
rtl/core/region_adjacency_from_watershed.sv
tb/sv/rag_checker.sv
tb/sv/tb.sv
